// ===== rtl/fpes_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the fixed-point exponential series block.
// No dependencies; every other file imports this package.
package fpes_pkg;

    localparam int X_W   = 31;  // Q0.31 argument and series term
    localparam int OUT_W = 26;  // Q.24 result
    localparam int ADD_W = 24;  // term shifted right by TERM_SHIFT
    localparam int J_W   = 6;   // series index 2 .. 33
    localparam int CNT_W = 5;   // divider step counter 0 .. X_W-1

    localparam int TERM_SHIFT = 7;

    localparam logic [OUT_W-1:0] ONE_Q24 = OUT_W'(16777216);
    localparam logic [J_W-1:0]   J_FIRST = J_W'(2);
    localparam logic [J_W-1:0]   J_LAST  = J_W'(33);
    localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(X_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/fpes_in_if.sv =====
`timescale 1ns / 1ps
// Request channel carrying the Q0.31 argument.
// Depends on fpes_pkg for the field width.
interface fpes_in_if import fpes_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [X_W-1:0]   x_value;

    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);
endinterface

// ===== rtl/fpes_out_if.sv =====
`timescale 1ns / 1ps
// Result channel carrying e^x in Q.24.
// Depends on fpes_pkg for the field width.
interface fpes_out_if import fpes_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] exp_value;

    modport source (output valid, output exp_value, input ready);
    modport sink   (input valid, input exp_value, output ready);
endinterface

// ===== rtl/fixed_point_exp_series.sv =====
`timescale 1ns / 1ps
// Exponential of a Q0.31 fraction by a truncated Taylor series, result in Q.24.
// Depends on fpes_pkg, fpes_in_if, fpes_out_if and fpes_div.
//
// Usage:
//   i_in  carries x_value (Q0.31, [0,1)); it is ready only while the sequencer
//         is idle, so one request is worked on at a time.
//   o_out carries exp_value (Q.24, 1.0 .. e) from an output register, so a
//         finished result may wait there while the next request is taken.
// Each series term costs one multiply step, a pass through the shared
// bit-serial divider plus a done step, and one accumulate step. A request
// runs at most 11 terms for any argument; x = 0 ends after one term. The
// divider's one-bit-per-cycle loop takes most of each term's time.
// Reset returns the sequencer to idle and drops any pending result.
// If the receiver stalls, the finished result is held; a second finished
// result waits in the sequencer until the output register frees up.
module fixed_point_exp_series import fpes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpes_in_if.sink     i_in,
    fpes_out_if.source  o_out
);

    t_state             r_state, n_state;
    logic [X_W-1:0]     r_x, n_x;
    logic [X_W-1:0]     r_term, n_term;
    logic [OUT_W-1:0]   r_sum, n_sum;
    logic [J_W-1:0]     r_j, n_j;
    logic               r_out_valid, n_out_valid;
    logic [OUT_W-1:0]   r_out_data, n_out_data;

    logic [2*X_W-1:0]   w_prod;
    logic [ADD_W-1:0]   w_add;
    logic               w_div_start;
    t_div_stat          w_div_stat;
    logic [X_W-1:0]     w_quo;

    // term * x >> 31 equals (term * x >> 7) >> 24, and the Q.24 index then
    // reduces to a plain integer divisor
    assign w_prod = (2*X_W)'(r_term) * (2*X_W)'(r_x);
    assign w_add  = r_term[X_W-1:TERM_SHIFT];

    fpes_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod[2*X_W-1:X_W]),
        .i_divisor  (r_j),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_term      = r_term;
        n_sum       = r_sum;
        n_j         = r_j;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_div_start = 1'b0;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_x     = i_in.x_value;
                    n_term  = i_in.x_value;
                    n_sum   = ONE_Q24 + OUT_W'(i_in.x_value[X_W-1:TERM_SHIFT]);
                    n_j     = J_FIRST;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    n_term  = w_quo;
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                // stop on a vanishing term or after the last index
                if (w_add == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_sum = r_sum + OUT_W'(w_add);
                    if (r_j == J_LAST) begin
                        n_state = ST_DONE;
                    end else begin
                        n_j     = r_j + J_W'(1);
                        n_state = ST_MUL;
                    end
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_sum;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_term     <= n_term;
        r_sum      <= n_sum;
        r_j        <= n_j;
        r_out_data <= n_out_data;
    end

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.exp_value = r_out_data;

endmodule

// ===== rtl/fpes_div.sv =====
`timescale 1ns / 1ps
// Restoring divider: 31-bit dividend by a small index, one quotient bit per cycle.
// Depends on fpes_pkg for widths and the status struct.
module fpes_div import fpes_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [X_W-1:0]   i_dividend,
    input  logic [J_W-1:0]   i_divisor,
    output t_div_stat        o_stat,
    output logic [X_W-1:0]   o_quotient
);

    logic [X_W-1:0]   r_work, n_work;
    logic [J_W-1:0]   r_rem, n_rem;
    logic [J_W-1:0]   r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [J_W+1:0]   w_diff;
    logic             w_ge;

    // trial subtract of the divisor from the shifted partial remainder
    assign w_diff = {1'b0, r_rem, r_work[X_W-1]} - {2'b00, r_den};
    assign w_ge   = ~w_diff[J_W+1];

    always_comb begin
        n_work = r_work;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_work = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_work = {r_work[X_W-2:0], w_ge};
            n_rem  = w_ge ? w_diff[J_W-1:0] : {r_rem[J_W-2:0], r_work[X_W-1]};
            n_cnt  = r_cnt + CNT_W'(1);
            if (r_cnt == DIV_LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_work;

endmodule

// ===== rtl/fpes_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks for fixed_point_exp_series, attached by bind.
// Depends on fpes_pkg for widths and the Q.24 one.
module fpes_chk import fpes_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [OUT_W-1:0] i_exp_value
);

    localparam logic [OUT_W-1:0] E_Q24 = OUT_W'(45605202);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_exp_value >= ONE_Q24) && (i_exp_value <= E_Q24))
        else $error("result outside 1.0 .. e");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one in flight");

    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result appeared without series work");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("reset did not clear the block");

endmodule

bind fixed_point_exp_series fpes_chk u_fpes_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_exp_value (o_out.exp_value)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for fixed_point_exp_series: drives Q0.31 arguments and checks each e^x result
// against a bit-exact Taylor series predictor kept in a small scoreboard class.
// Depends on fpes_pkg, fpes_in_if, fpes_out_if and the block's RTL.
module tb;
    import fpes_pkg::*;

    typedef struct {
        logic [X_W-1:0]   x_value;
        logic [OUT_W-1:0] exp_value;
    } t_exp_entry;

    class exp_scoreboard;
        t_exp_entry exp_q[$];
        int         n_args;
        int         n_checked;
        int         n_errors;

        function new();
            n_args    = 0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        // Series sum: 1.0 + x/128, then term = (term * x >> 7) / (j in Q.24), j = 2, 3, ...
        static function logic [OUT_W-1:0] series_exp(logic [X_W-1:0] x);
            logic [31:0] acc;
            logic [63:0] term;
            logic [63:0] prod;
            logic [63:0] divisor;
            logic [63:0] add_v;
            acc     = 32'(ONE_Q24) + 32'(x >> TERM_SHIFT);
            term    = 64'(x);
            divisor = 64'(ONE_Q24);
            for (int k = 0; k < 32; k++) begin
                prod    = (term * 64'(x)) >> TERM_SHIFT;
                divisor = divisor + 64'(ONE_Q24);
                term    = prod / divisor;
                add_v   = term >> TERM_SHIFT;
                if (add_v == 64'd0) break;
                acc = acc + add_v[31:0];
            end
            return acc[OUT_W-1:0];
        endfunction

        function void note_arg(logic [X_W-1:0] x);
            t_exp_entry e;
            e.x_value   = x;
            e.exp_value = series_exp(x);
            exp_q.push_back(e);
            n_args++;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            n_errors++;
        endtask

        task check_result(logic [OUT_W-1:0] got);
            t_exp_entry e;
            if (exp_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result exp_value=%0d", got));
            end else begin
                e = exp_q.pop_front();
                n_checked++;
                if (got !== e.exp_value)
                    report_mismatch($sformatf("x=%0d exp_value got %0d expected %0d",
                                              e.x_value, got, e.exp_value));
            end
        endtask

        function int pending();
            return exp_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   n_random;

    fpes_in_if  in_if();
    fpes_out_if out_if();

    exp_scoreboard sb = new();

    fixed_point_exp_series i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: decide ready at the falling edge, take results at the rising edge.
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            sb.check_result(out_if.exp_value);
    end

    task automatic send_arg(input logic [X_W-1:0] x);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.x_value <= x;
        do @(posedge i_clk); while (!(in_if.valid === 1'b1 && in_if.ready === 1'b1));
        sb.note_arg(x);
    endtask

    function automatic logic [X_W-1:0] random_arg();
        logic [X_W-1:0] x;
        int             pick;
        pick = $urandom_range(99);
        x    = X_W'($urandom);
        if (pick < 15)
            x = X_W'($urandom_range(255));
        else if (pick < 30)
            x = {X_W{1'b1}} - X_W'($urandom_range(4095));
        else if (pick < 40)
            x = X_W'(1) << $urandom_range(X_W - 1);
        else if (pick < 50)
            x = x & X_W'($urandom) & X_W'($urandom);
        return x;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_arg(random_arg());
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.x_value = '0;
        out_if.ready  = 1'b0;
        src_idle_pct  = 0;
        snk_idle_pct  = 0;
        n_random      = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero, the x >> 7 boundary, single bits, alternating patterns, the top of the range.
        send_arg(X_W'(0));
        send_arg(X_W'(1));
        send_arg(X_W'(127));
        send_arg(X_W'(128));
        send_arg(X_W'(129));
        send_arg(X_W'(255));
        for (int b = 8; b < X_W; b += 3)
            send_arg(X_W'(1) << b);
        send_arg(X_W'(31'h4000_0000));
        send_arg(X_W'(31'h5555_5555));
        send_arg(X_W'(31'h2AAA_AAAA));
        send_arg({X_W{1'b1}} - X_W'(1));
        send_arg({X_W{1'b1}});
        send_arg(X_W'(0));

        src_idle_pct = 9;
        snk_idle_pct = 82;
        run_random(280);
        src_idle_pct = 82;
        snk_idle_pct = 9;
        run_random(280);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(280);
        n_random = 840;

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        // Allow one more request's worth of cycles for stray results.
        repeat (400) @(posedge i_clk);

        $display("Sent %0d arguments (%0d random) across three handshake pressure phases;",
                 sb.n_args, n_random);
        $display("checked %0d results, %0d mismatches.", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("Timeout with %0d results outstanding", sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
